/* rtl/pcg_pkg.sv */
package pcg_pkg;

  // LCG constants and the reset state of the generator
  localparam logic [63:0] LcgMul     = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LcgInc     = 64'hDA3E_39CB_94B9_5BDB;
  localparam logic [63:0] StateReset = 64'h853C_49E6_748F_EA9B;

  // XSH-RR output permutation
  localparam int unsigned XshShift = 18;
  localparam int unsigned XshLow   = 27;
  localparam int unsigned RotLow   = 59;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SeedW  = 64;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned ModCntW = 5;

  // Request codes on func
  localparam logic [FuncW-1:0] FuncRaw     = 2'd0;
  localparam logic [FuncW-1:0] FuncBounded = 2'd1;
  localparam logic [FuncW-1:0] FuncReseed  = 2'd2;

  typedef enum logic [1:0] {
    OP_RAW,
    OP_BOUNDED,
    OP_RESEED,
    OP_NOP
  } op_e;

  // One classified request, front to back
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] bound;
    logic [SeedW-1:0] seed;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_MOD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_BMUL,
    S_BCHK,
    S_DONE
  } state_e;

  // 32-bit permuted output of a 64-bit state
  function automatic logic [WordW-1:0] xsh_rr(input logic [SeedW-1:0] s);
    logic [SeedW-1:0]   mixed;
    logic [WordW-1:0]   x;
    logic [4:0]         amt;
    logic [2*WordW-1:0] dbl;
    mixed = s ^ (s >> XshShift);
    x     = mixed[XshLow +: WordW];
    amt   = s[RotLow +: 5];
    dbl   = {x, x} >> amt;
    return dbl[WordW-1:0];
  endfunction

endpackage

/* rtl/pcg_front.sv */
module pcg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcg_pkg::FuncW-1:0]     func_i,
  input  logic [pcg_pkg::WordW-1:0]     bound_i,
  input  logic [pcg_pkg::SeedW-1:0]     seed_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output pcg_pkg::cmd_t                 cmd_o
);

  // two-entry queue of classified words
  pcg_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;
  pcg_pkg::cmd_t new_cmd;

  always_comb begin
    new_cmd.bound = bound_i;
    new_cmd.seed  = seed_i;
    case (func_i)
      pcg_pkg::FuncRaw:     new_cmd.op = pcg_pkg::OP_RAW;
      pcg_pkg::FuncBounded: new_cmd.op = pcg_pkg::OP_BOUNDED;
      pcg_pkg::FuncReseed:  new_cmd.op = pcg_pkg::OP_RESEED;
      default:              new_cmd.op = pcg_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

/* rtl/pcg_back.sv */
module pcg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  pcg_pkg::cmd_t             cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pcg_pkg::WordW-1:0] value_o
);

  localparam int unsigned W = pcg_pkg::WordW;

  pcg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     gen_q, gen_d;

  pcg_pkg::op_e    op_q, op_d;
  logic [W-1:0]    bound_q, bound_d;
  logic [63:0]     seed_q, seed_d;
  logic [W-1:0]    word_q, word_d;
  logic [63:0]     prod_q, prod_d;
  logic [63:0]     acc_q, acc_d;
  logic [W-1:0]    thresh_q, thresh_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    div_q, div_d;
  logic [pcg_pkg::ModCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    res_q, res_d;
  logic [W-1:0]    value_q, value_d;

  logic [W-1:0]    mul_a, mul_b;
  logic [W:0]      rem_sh, rem_sub;
  logic [W-1:0]    rem_nxt;

  assign cmd_ready_o = (state_q == pcg_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // restoring remainder step, one dividend bit per cycle
  assign rem_sh  = {rem_q, div_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, bound_q};
  assign rem_nxt = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];

  // shared 32x32 multiplier operand select
  always_comb begin
    case (state_q)
      pcg_pkg::S_M0: begin
        mul_a = gen_q[W-1:0];
        mul_b = pcg_pkg::LcgMul[W-1:0];
      end
      pcg_pkg::S_M1: begin
        mul_a = gen_q[W-1:0];
        mul_b = pcg_pkg::LcgMul[2*W-1:W];
      end
      pcg_pkg::S_M2: begin
        mul_a = gen_q[2*W-1:W];
        mul_b = pcg_pkg::LcgMul[W-1:0];
      end
      default: begin
        mul_a = word_q;
        mul_b = bound_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    gen_d       = gen_q;
    op_d        = op_q;
    bound_d     = bound_q;
    seed_d      = seed_q;
    word_d      = word_q;
    prod_d      = {32'd0, mul_a} * {32'd0, mul_b};
    acc_d       = acc_q;
    thresh_d    = thresh_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    value_d     = value_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pcg_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          op_d     = cmd_i.op;
          bound_d  = cmd_i.bound;
          seed_d   = cmd_i.seed;
          thresh_d = '0;
          rem_d    = '0;
          div_d    = '0 - cmd_i.bound;
          cnt_d    = '0;
          case (cmd_i.op)
            pcg_pkg::OP_RAW:     state_d = pcg_pkg::S_M0;
            pcg_pkg::OP_BOUNDED: begin
              state_d = (cmd_i.bound == '0) ? pcg_pkg::S_M0 : pcg_pkg::S_MOD;
            end
            pcg_pkg::OP_RESEED:  state_d = pcg_pkg::S_SEED;
            default: begin
              res_d   = '0;
              state_d = pcg_pkg::S_DONE;
            end
          endcase
        end
      end
      pcg_pkg::S_SEED: begin
        gen_d   = pcg_pkg::LcgInc + seed_q;
        state_d = pcg_pkg::S_M0;
      end
      pcg_pkg::S_MOD: begin
        rem_d = rem_nxt;
        div_d = {div_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          thresh_d = rem_nxt;
          state_d  = pcg_pkg::S_M0;
        end
      end
      pcg_pkg::S_M0: begin
        word_d  = pcg_pkg::xsh_rr(gen_q);
        state_d = pcg_pkg::S_M1;
      end
      pcg_pkg::S_M1: begin
        acc_d   = prod_q + pcg_pkg::LcgInc;
        state_d = pcg_pkg::S_M2;
      end
      pcg_pkg::S_M2: begin
        acc_d   = {acc_q[2*W-1:W] + prod_q[W-1:0], acc_q[W-1:0]};
        state_d = pcg_pkg::S_M3;
      end
      pcg_pkg::S_M3: begin
        gen_d = {acc_q[2*W-1:W] + prod_q[W-1:0], acc_q[W-1:0]};
        case (op_q)
          pcg_pkg::OP_BOUNDED: state_d = pcg_pkg::S_BMUL;
          pcg_pkg::OP_RAW: begin
            res_d   = word_q;
            state_d = pcg_pkg::S_DONE;
          end
          default: begin
            res_d   = '0;
            state_d = pcg_pkg::S_DONE;
          end
        endcase
      end
      pcg_pkg::S_BMUL: begin
        state_d = pcg_pkg::S_BCHK;
      end
      pcg_pkg::S_BCHK: begin
        // low word under the threshold: reject and draw again
        if (prod_q[W-1:0] < thresh_q) begin
          state_d = pcg_pkg::S_M0;
        end else begin
          res_d   = prod_q[2*W-1:W];
          state_d = pcg_pkg::S_DONE;
        end
      end
      pcg_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          state_d     = pcg_pkg::S_IDLE;
        end
      end
      default: state_d = pcg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcg_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      gen_q       <= pcg_pkg::StateReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      gen_q       <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    bound_q  <= bound_d;
    seed_q   <= seed_d;
    word_q   <= word_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    thresh_q <= thresh_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
    value_q  <= value_d;
  end

endmodule

/* rtl/pcg32_bounded_random_top.sv */
// Raw draw: states S_M0 to S_M3, then S_DONE; a reseed passes S_SEED first, and an
// unused code goes straight to S_DONE. Bounded draw: a bit-serial remainder (S_MOD)
// for the reject threshold, then per draw the LCG step on the shared 32x32 multiplier
// (S_M0 to S_M3) and word*bound (S_BMUL, S_BCHK); the next request waits for S_IDLE.
// Reset (rst_ni low, async): generator state 0x853C49E6748FEA9B, queue and output empty.
module pcg32_bounded_random_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcg_pkg::FuncW-1:0]     func_i,
  input  logic [pcg_pkg::WordW-1:0]     bound_i,
  input  logic [pcg_pkg::SeedW-1:0]     seed_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcg_pkg::WordW-1:0]     value_o
);

  // Front: classifies the func code and buffers up to two request words,
  // so a new word is taken while the back end is still busy.
  pcg_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  pcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .bound_i     (bound_i),
    .seed_i      (seed_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: sequencer holding the 64-bit state. The LCG step is done as three
  // 32x32 partial products on one multiplier; the threshold (2^32-bound) mod
  // bound comes from a restoring remainder unit. The threshold is computed
  // for every nonzero bound: a low word at or above bound is always above it,
  // so the reject test stays the same. The output register lets the next
  // request start while a finished word waits.
  pcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

endmodule
